FILE: sv/plt_pkg.sv
// Shared types and constants for the percentile latency throttle.
package plt_pkg;

    localparam int IDX_W = 8;
    localparam int DVD_W = 42;
    localparam int DVS_W = 32;

    typedef enum logic [2:0] {
        CFG_MAX_SLEEP = 3'd0,
        CFG_CEILING   = 3'd1,
        CFG_STALENESS = 3'd2,
        CFG_RATIO_LOW = 3'd3,
        CFG_RATIO_HIGH = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] sample_lat;
        logic [47:0] now_us;
    } item_t;

    typedef struct packed {
        logic [25:0] sleep_time;
        logic        updated;
    } result_t;

    typedef struct packed {
        logic             record;
        logic             clear;
        logic             compute;
        logic             zero_out;
        logic [IDX_W-1:0] widx;
        logic [31:0]      latency;
    } cmd_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

endpackage

FILE: sv/percentile_latency_throttle.sv
// Top level of the percentile latency throttle.
//
// channel  | handshake                 | payload
// item     | push / full               | item (mode, sample_lat, now_us)
// result   | pop / empty               | result (sleep_time, updated)
// config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A query or a record that does not close a window goes from the back end's
// idle state straight to its response state, then into the result queue.
// A record that closes a window adds rank selection over the sample ring,
// read through its two read ports, and up to two runs of the shared serial
// divider. Reset clears control state and counters; the ring
// holds no valid bits. Two-entry queues sit between front, back and result;
// a full result queue holds the back end, a full command queue raises full.
module percentile_latency_throttle #(
    parameter int WINDOW = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  plt_pkg::item_t    item,
    output logic              empty,
    input  logic              pop,
    output plt_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import plt_pkg::*;

    logic [15:0]       max_sleep_reg;
    logic [31:0]       ceiling_reg;
    logic [31:0]       staleness_reg;
    logic [15:0]       ratio_low_reg;
    logic [15:0]       ratio_high_reg;
    logic              accept;
    cmd_t              cmd_in;
    cmd_t              cmd_out;
    logic              cmd_empty;
    logic              cmd_pop;
    logic              rsp_full;
    logic              rsp_push;
    result_t           rsp;
    div_ctl_t          div_ctl;
    logic              div_busy;
    logic              div_done;
    logic [DVD_W-1:0]  div_quot;
    logic [DVD_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_sleep_reg  <= 16'd0;
            ceiling_reg    <= 32'd0;
            staleness_reg  <= 32'd5000000;
            ratio_low_reg  <= 16'd384;
            ratio_high_reg <= 16'd768;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MAX_SLEEP:  max_sleep_reg  <= cfg_data[15:0];
                CFG_CEILING:    ceiling_reg    <= cfg_data;
                CFG_STALENESS:  staleness_reg  <= cfg_data;
                CFG_RATIO_LOW:  ratio_low_reg  <= cfg_data[15:0];
                CFG_RATIO_HIGH: ratio_high_reg <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    plt_front #(.WINDOW(WINDOW)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .stale_limit (staleness_reg),
        .cmd         (cmd_in)
    );

    plt_fifo #(.T(cmd_t), .DEPTH(2)) u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (accept),
        .wdata (cmd_in),
        .rd    (cmd_pop),
        .rdata (cmd_out),
        .full  (full),
        .empty (cmd_empty)
    );

    plt_back #(.WINDOW(WINDOW)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_out),
        .cmd_empty    (cmd_empty),
        .cmd_pop      (cmd_pop),
        .sleep_cap_ms (max_sleep_reg),
        .p50_limit    (ceiling_reg),
        .spread_lo    (ratio_low_reg),
        .spread_hi    (ratio_high_reg),
        .rsp_full     (rsp_full),
        .rsp_push     (rsp_push),
        .rsp          (rsp),
        .div_ctl      (div_ctl),
        .div_busy     (div_busy),
        .div_done     (div_done),
        .div_quot     (div_quot),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor)
    );

    plt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_ctl.start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    plt_fifo #(.T(result_t), .DEPTH(2)) u_rspq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (rsp_push),
        .wdata (rsp),
        .rd    (pop),
        .rdata (result),
        .full  (rsp_full),
        .empty (empty)
    );
endmodule

FILE: sv/plt_fifo.sv
// Small register FIFO used between the stages and on the result side.
module plt_fifo #(
    parameter type T = logic,
    parameter int DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  T     wdata,
    input  logic rd,
    output T     rdata,
    output logic full,
    output logic empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T               mem [DEPTH];
    logic [PW-1:0]  wp_reg;
    logic [PW-1:0]  rp_reg;
    logic [CW-1:0]  cnt_reg;
    logic           do_wr;
    logic           do_rd;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule

FILE: sv/plt_div.sv
// Restoring divider, one quotient bit per cycle.
module plt_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [plt_pkg::DVD_W-1:0] dividend,
    input  logic [plt_pkg::DVS_W-1:0] divisor,
    output logic                      busy,
    output logic                      done,
    output logic [plt_pkg::DVD_W-1:0] quotient
);
    import plt_pkg::*;

    localparam int NW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [NW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic             fits;

    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= NW'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == NW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
        end
    end
endmodule

FILE: sv/plt_front.sv
// Front end: staleness check, window bookkeeping and command build.
module plt_front #(
    parameter int WINDOW = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  plt_pkg::item_t item,
    input  logic [31:0]    stale_limit,
    output plt_pkg::cmd_t  cmd
);
    import plt_pkg::*;

    localparam int LW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);

    logic [47:0]   last_reg;
    logic [LW-1:0] widx_reg;
    logic [CW-1:0] fill_reg;
    logic [47:0]   gap;
    logic          stale;
    logic [CW-1:0] fill_after;
    logic          complete;

    assign gap        = item.now_us - last_reg;
    assign stale      = (last_reg != '0) && (gap > {16'd0, stale_limit});
    assign fill_after = (stale ? '0 : fill_reg) + 1'b1;
    assign complete   = (fill_after == CW'(WINDOW));

    always_comb
    begin
        cmd.record   = !item.mode;
        cmd.clear    = !item.mode && stale;
        cmd.compute  = !item.mode && complete;
        cmd.zero_out = item.mode ? ((last_reg == '0) || stale) : (item.now_us == '0);
        cmd.widx     = IDX_W'(widx_reg);
        cmd.latency  = item.sample_lat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            widx_reg <= '0;
            fill_reg <= '0;
        end
        else if (accept && !item.mode)
        begin
            last_reg <= item.now_us;
            widx_reg <= (widx_reg == LW'(WINDOW - 1)) ? '0 : widx_reg + 1'b1;
            fill_reg <= complete ? '0 : fill_after;
        end
    end
endmodule

FILE: sv/plt_back.sv
// Back end: sample ring, rank selection, sleep computation and result build.
module plt_back #(
    parameter int WINDOW = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  plt_pkg::cmd_t             cmd,
    input  logic                      cmd_empty,
    output logic                      cmd_pop,
    input  logic [15:0]               sleep_cap_ms,
    input  logic [31:0]               p50_limit,
    input  logic [15:0]               spread_lo,
    input  logic [15:0]               spread_hi,
    input  logic                      rsp_full,
    output logic                      rsp_push,
    output plt_pkg::result_t          rsp,
    output plt_pkg::div_ctl_t         div_ctl,
    input  logic                      div_busy,
    input  logic                      div_done,
    input  logic [plt_pkg::DVD_W-1:0] div_quot,
    output logic [plt_pkg::DVD_W-1:0] div_dividend,
    output logic [plt_pkg::DVS_W-1:0] div_divisor
);
    import plt_pkg::*;

    localparam int LW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);
    localparam int RANK_MID = (WINDOW - 1) / 2;
    localparam int RANK_HIGH = (95 * WINDOW + 99) / 100 - 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_SCAN, ST_CHECK, ST_MATH,
        ST_DIV1, ST_RATIO, ST_MUL, ST_DIV2S, ST_DIV2, ST_RESP
    } state_t;

    state_t        state_reg;
    logic [31:0]   ring [WINDOW];
    logic [31:0]   cand_rd;
    logic [31:0]   swp_rd;
    logic [LW-1:0] ci_reg;
    logic [CW-1:0] sj_reg;
    logic [CW-1:0] lt_reg;
    logic [CW-1:0] le_reg;
    logic [31:0]   p50_reg;
    logic [31:0]   p95_reg;
    logic [39:0]   ratio_reg;
    logic [15:0]   over_reg;
    logic [41:0]   prod_reg;
    logic [25:0]   sleep_reg;
    logic          upd_reg;
    logic          zero_reg;
    logic [25:0]   full;
    logic [15:0]   span;
    logic [39:0]   excess;
    logic          math_div;

    assign full     = 26'(sleep_cap_ms) * 26'd1000;
    assign span     = spread_hi - spread_lo;
    assign excess   = ratio_reg - {24'd0, spread_lo};
    assign math_div = (p50_reg != '0) && !((p50_limit != '0) && (p50_reg > p50_limit));

    assign cmd_pop        = (state_reg == ST_IDLE) && !cmd_empty;
    assign rsp_push       = (state_reg == ST_RESP) && !rsp_full;
    assign rsp.sleep_time = zero_reg ? '0 : sleep_reg;
    assign rsp.updated    = upd_reg;
    assign div_ctl.start  = ((state_reg == ST_MATH) && math_div) || (state_reg == ST_DIV2S);
    assign div_ctl.busy   = div_busy;
    assign div_ctl.done   = div_done;
    assign div_dividend   = (state_reg == ST_MATH) ? {2'b00, p95_reg, 8'd0} : prod_reg;
    assign div_divisor    = (state_reg == ST_MATH) ? p50_reg : {16'd0, span};

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.record)
        begin
            ring[cmd.widx[LW-1:0]] <= cmd.latency;
        end
        cand_rd <= ring[ci_reg];
        swp_rd  <= ring[sj_reg[LW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sleep_reg <= '0;
            upd_reg   <= 1'b0;
            zero_reg  <= 1'b0;
            ci_reg    <= '0;
            sj_reg    <= '0;
            lt_reg    <= '0;
            le_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        if (cmd.clear)
                        begin
                            sleep_reg <= '0;
                        end
                        zero_reg  <= cmd.zero_out;
                        upd_reg   <= cmd.compute;
                        ci_reg    <= '0;
                        state_reg <= cmd.compute ? ST_LOAD : ST_RESP;
                    end
                end
                ST_LOAD:
                begin
                    lt_reg    <= '0;
                    le_reg    <= '0;
                    sj_reg    <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (sj_reg != '0)
                    begin
                        lt_reg <= lt_reg + CW'(swp_rd < cand_rd);
                        le_reg <= le_reg + CW'(swp_rd <= cand_rd);
                    end
                    if (sj_reg == CW'(WINDOW))
                    begin
                        state_reg <= ST_CHECK;
                    end
                    else
                    begin
                        sj_reg <= sj_reg + 1'b1;
                    end
                end
                ST_CHECK:
                begin
                    if (lt_reg <= CW'(RANK_MID) && le_reg > CW'(RANK_MID))
                    begin
                        p50_reg <= cand_rd;
                    end
                    if (lt_reg <= CW'(RANK_HIGH) && le_reg > CW'(RANK_HIGH))
                    begin
                        p95_reg <= cand_rd;
                    end
                    if (ci_reg == LW'(WINDOW - 1))
                    begin
                        state_reg <= ST_MATH;
                    end
                    else
                    begin
                        ci_reg    <= ci_reg + 1'b1;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_MATH:
                begin
                    if (p50_reg == '0)
                    begin
                        sleep_reg <= '0;
                        state_reg <= ST_RESP;
                    end
                    else if (!math_div)
                    begin
                        sleep_reg <= full;
                        state_reg <= ST_RESP;
                    end
                    else
                    begin
                        state_reg <= ST_DIV1;
                    end
                end
                ST_DIV1:
                begin
                    if (div_done)
                    begin
                        ratio_reg <= div_quot[39:0];
                        state_reg <= ST_RATIO;
                    end
                end
                ST_RATIO:
                begin
                    if (ratio_reg < {24'd0, spread_lo})
                    begin
                        sleep_reg <= '0;
                        state_reg <= ST_RESP;
                    end
                    else if (spread_hi <= spread_lo)
                    begin
                        sleep_reg <= full;
                        state_reg <= ST_RESP;
                    end
                    else
                    begin
                        over_reg  <= (excess > {24'd0, span}) ? span : excess[15:0];
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= 42'(over_reg) * 42'(full);
                    state_reg <= ST_DIV2S;
                end
                ST_DIV2S:
                begin
                    state_reg <= ST_DIV2;
                end
                ST_DIV2:
                begin
                    if (div_done)
                    begin
                        sleep_reg <= div_quot[25:0];
                        state_reg <= ST_RESP;
                    end
                end
                ST_RESP:
                begin
                    if (!rsp_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_push |-> !rsp_full) else $error("result pushed while full");
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.start |-> !div_busy) else $error("divider restarted while busy");
    a_rank_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> (le_reg > lt_reg)) else $error("rank counts inconsistent");
    a_no_update_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_push && !rsp.updated) |->
        ($past(state_reg) == ST_IDLE || $past(state_reg) == ST_RESP))
        else $error("plain transaction took the compute path");
`endif
endmodule
